@@ rtl/core/bmp_rle8_decoder_defines.svh @@
// assertion macros used by the decoder fsm file
`ifndef BMP_RLE8_DECODER_DEFINES_SVH
`define BMP_RLE8_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define BMPRLE8_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bmp_rle8_decoder: assertion failed");
`define BMPRLE8_ASSERT_NEVER(name, clk, rst, cond) \
   `BMPRLE8_ASSERT(name, clk, rst, !(cond))
`else
`define BMPRLE8_ASSERT(name, clk, rst, prop)
`define BMPRLE8_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

@@ rtl/core/bmprle8_pkg.sv @@
package bmprle8_pkg;

   // escape code bytes
   localparam logic [7:0] CODE_EOL   = 8'd0;
   localparam logic [7:0] CODE_EOB   = 8'd1;
   localparam logic [7:0] CODE_DELTA = 8'd2;

   // bytes that follow a delta escape
   localparam logic [7:0] DELTA_LEN  = 8'd2;

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_VALUE   = 3'd1,
      PH_ESCAPE  = 3'd2,
      PH_DELTA   = 3'd3,
      PH_LITERAL = 3'd4,
      PH_PAD     = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic [7:0] repeat_count;
      logic       end_of_image;
   } rsp_type;

   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } dec_type;

endpackage

@@ rtl/core/bmp_rle8_decoder.sv @@
// bitmap rle8 stream decoder, one compressed byte per item
// a run's last byte enters the input register, then its result loads the result register that offers it
// throughput: 1 byte per cycle while the result side keeps taking items
// the bound is the combinational phase update between input and result register
// reset (synchronous, active high) empties both registers and returns to pair start
module bmp_rle8_decoder
   import bmprle8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_stream_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_pixel_value,
   output logic [7:0] rsp_repeat_count,
   output logic       rsp_end_of_image
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // byte moves through the decoder when the result register has room
   logic       advance;
   dec_type    dec;
   rsp_type    rsp;

   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   // phase tracking and run decode
   bmprle8_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .dec     (dec)
   );

   // result register between decode and consumer
   bmprle8_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .dec       (dec),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_pixel_value  = rsp.pixel_value;
   assign rsp_repeat_count = rsp.repeat_count;
   assign rsp_end_of_image = rsp.end_of_image;

endmodule

@@ rtl/core/bmprle8_fsm.sv @@
`include "bmp_rle8_decoder_defines.svh"

module bmprle8_fsm
   import bmprle8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   output dec_type    dec
);

   phase_type  phase_ff,        phase_in;
   logic [7:0] held_count_ff,   held_count_in;
   logic [7:0] literal_left_ff, literal_left_in;
   logic       pad_pending_ff,  pad_pending_in;

   // next state
   always_comb begin
      phase_in        = phase_ff;
      held_count_in   = held_count_ff;
      literal_left_in = literal_left_ff;
      pad_pending_in  = pad_pending_ff;
      case (phase_ff)
         PH_VALUE: begin
            phase_in = PH_FIRST;
         end
         PH_ESCAPE: begin
            if (in_byte == CODE_EOB) begin
               phase_in        = PH_FIRST;
               held_count_in   = '0;
               literal_left_in = '0;
               pad_pending_in  = 1'b0;
            end else if (in_byte == CODE_DELTA) begin
               literal_left_in = DELTA_LEN;
               phase_in        = PH_DELTA;
            end else if (in_byte == CODE_EOL) begin
               phase_in = PH_FIRST;
            end else begin
               literal_left_in = in_byte;
               pad_pending_in  = in_byte[0];
               phase_in        = PH_LITERAL;
            end
         end
         PH_DELTA: begin
            literal_left_in = literal_left_ff - 8'd1;
            if (literal_left_ff == 8'd1) begin
               phase_in = PH_FIRST;
            end
         end
         PH_LITERAL: begin
            literal_left_in = literal_left_ff - 8'd1;
            if (literal_left_ff == 8'd1) begin
               phase_in = pad_pending_ff ? PH_PAD : PH_FIRST;
            end
         end
         PH_PAD: begin
            pad_pending_in = 1'b0;
            phase_in       = PH_FIRST;
         end
         default: begin
            if (in_byte != 8'd0) begin
               held_count_in = in_byte;
               phase_in      = PH_VALUE;
            end else begin
               phase_in = PH_ESCAPE;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      dec = '0;
      case (phase_ff)
         PH_VALUE: begin
            dec.emit             = 1'b1;
            dec.rsp.pixel_value  = in_byte;
            dec.rsp.repeat_count = held_count_ff;
         end
         PH_ESCAPE: begin
            if (in_byte == CODE_EOB) begin
               dec.emit             = 1'b1;
               dec.rsp.end_of_image = 1'b1;
            end
         end
         PH_LITERAL: begin
            dec.emit             = 1'b1;
            dec.rsp.pixel_value  = in_byte;
            dec.rsp.repeat_count = 8'd1;
         end
         default: begin
            dec = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_FIRST;
         held_count_ff   <= '0;
         literal_left_ff <= '0;
         pad_pending_ff  <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         held_count_ff   <= held_count_in;
         literal_left_ff <= literal_left_in;
         pad_pending_ff  <= pad_pending_in;
      end
   end

   `BMPRLE8_ASSERT(a_eob_clears, clock, reset, (step && dec.emit && dec.rsp.end_of_image) |=> (phase_ff == PH_FIRST && literal_left_ff == 8'd0 && !pad_pending_ff))
   `BMPRLE8_ASSERT(a_delta_len, clock, reset, (step && phase_ff == PH_ESCAPE && in_byte == CODE_DELTA) |=> (phase_ff == PH_DELTA && literal_left_ff == DELTA_LEN))
   `BMPRLE8_ASSERT(a_pad_flag, clock, reset, (phase_ff == PH_PAD) |-> pad_pending_ff)
   `BMPRLE8_ASSERT_NEVER(a_run_nonzero, clock, reset, dec.emit && !dec.rsp.end_of_image && dec.rsp.repeat_count == 8'd0)

endmodule

@@ rtl/core/bmprle8_out.sv @@
module bmprle8_out
   import bmprle8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  dec_type    dec,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output rsp_type    rsp
);

   logic    valid_ff;
   rsp_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load && dec.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && dec.emit) begin
         data_ff <= dec.rsp;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule
